FILE: src/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES package
// Shared constants and byte-level functions for the AES core.
// ----------------------------------------------------------------------------
`default_nettype none
package aes_pkg;

   localparam int unsigned KeyStoreDepth = 30;
   localparam int unsigned KeyAddrWidth  = 5;
   localparam int unsigned CsrIdxWidth   = 3;

   localparam logic [CsrIdxWidth-1:0] CSR_KEY_SIZE = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_KEY_W0   = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_KEY_W1   = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_KEY_W2   = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_KEY_W3   = 3'd4;

   localparam logic [1:0] KEY_SIZE_192 = 2'd1;
   localparam logic [1:0] KEY_SIZE_256 = 2'd2;

   localparam logic [7:0] RCON_INIT = 8'h01;
   localparam logic [7:0] GF_POLY   = 8'h1b;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

endpackage
`default_nettype wire

FILE: src/aes_block_cipher_128_192_256_core.sv
// ----------------------------------------------------------------------------
// AES block cipher core
// ECB encrypt/decrypt of 128-bit blocks with 128/192/256-bit keys.
// ----------------------------------------------------------------------------
// After any key register write, the first block triggers key expansion into a
// 30 x 64 round-key RAM: one 32-bit schedule word per cycle, 44/52/60 words.
// A block then passes from accept through the first round-key read (ST_LOAD),
// the initial key addition (ST_FIRST), one round per cycle (ST_ROUND) and the
// holding of the result (ST_DONE) back to ST_IDLE, which takes the next item.
// The round-key RAM read of the next round key overlaps each round. The
// result is held until taken; a stalled receiver stalls the input. One block
// at a time. Key registers are written only while idle, and a write waits
// while an input item is offered.
`default_nettype none
module aes_block_cipher_128_192_256_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_op,
   input  wire logic [63:0] req_block_hi,
   input  wire logic [63:0] req_block_lo,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [63:0] rsp_result_hi,
   output logic      [63:0] rsp_result_lo,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXPAND, ST_LOAD, ST_FIRST, ST_ROUND, ST_DONE
   } state_type;

   state_type    state_ff;
   logic [1:0]   key_size_ff;
   logic [63:0]  key_word_ff [4];
   logic         keys_ready_ff;

   // round-key RAM: two banks, high/low half of each round key
   logic [63:0]  rk_hi_mem [15];
   logic [63:0]  rk_lo_mem [15];
   logic [63:0]  rk_hi_rd_ff, rk_lo_rd_ff;
   logic [3:0]   rd_addr;

   // key expansion
   logic [5:0]   wi_ff;
   logic [31:0]  win_ff [8];
   logic [7:0]   rcon_ff;
   logic [2:0]   nk_pos_ff;
   logic [31:0]  hold_word_ff;
   logic [3:0]   nk;
   logic [5:0]   total_words;
   logic [3:0]   nrounds;
   logic [31:0]  new_word, tmp;
   logic [31:0]  cur_word;
   logic [63:0]  pair;

   logic         op_ff;
   logic [127:0] st_ff;
   logic [3:0]   rnd_ff;
   logic [127:0] round_out;
   logic         last;
   logic         csr_hit;

   always_comb begin
      unique case (key_size_ff)
         aes_pkg::KEY_SIZE_192: nk = 4'd6;
         aes_pkg::KEY_SIZE_256: nk = 4'd8;
         default:               nk = 4'd4;
      endcase
      nrounds     = nk + 4'd6;
      total_words = {nrounds, 2'b00} + 6'd4;
   end

   // schedule word i: window holds w[i-nk..i-1] at win[0..nk-1]
   always_comb begin
      tmp = win_ff[3'(nk - 4'd1)];
      if (nk_pos_ff == 3'd0) begin
         tmp = aes_pkg::sub_word({tmp[23:0], tmp[31:24]}) ^ {rcon_ff, 24'h0};
      end else if (nk == 4'd8 && nk_pos_ff == 3'd4) begin
         tmp = aes_pkg::sub_word(tmp);
      end
      new_word = win_ff[0] ^ tmp;
   end

   // key words pass first, then computed schedule words
   assign cur_word  = (wi_ff < {2'b00, nk}) ? win_ff[wi_ff[2:0]] : new_word;
   assign pair      = {hold_word_ff, cur_word};

   assign csr_ready = (state_ff == ST_IDLE) && !req_valid;
   assign csr_hit   = csr_valid && csr_ready && csr_index <= aes_pkg::CSR_KEY_W3;
   assign req_ready = (state_ff == ST_IDLE);
   assign last      = (rnd_ff == nrounds);

   always_comb begin
      rd_addr = op_ff ? (nrounds - rnd_ff - 4'd1) : (rnd_ff + 4'd1);
      if (state_ff == ST_LOAD) begin
         rd_addr = op_ff ? nrounds : 4'd0;
      end
   end

   aes_round u_round (
      .state_i   (st_ff),
      .key_i     ({rk_hi_rd_ff, rk_lo_rd_ff}),
      .inverse_i (op_ff),
      .last_i    (last),
      .state_o   (round_out)
   );

   // odd schedule words complete a 64-bit pair: word 4r+1 ends the high half
   // of round key r, word 4r+3 the low half
   always_ff @(posedge clock) begin
      rk_hi_rd_ff <= rk_hi_mem[rd_addr];
      rk_lo_rd_ff <= rk_lo_mem[rd_addr];
      if (state_ff == ST_EXPAND && wi_ff[0]) begin
         if (wi_ff[1]) begin
            rk_lo_mem[wi_ff[5:2]] <= pair;
         end else begin
            rk_hi_mem[wi_ff[5:2]] <= pair;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         key_size_ff   <= '0;
         keys_ready_ff <= 1'b0;
         rsp_valid     <= 1'b0;
         for (int i = 0; i < 4; i++) key_word_ff[i] <= '0;
      end else begin
         if (csr_hit) begin
            keys_ready_ff <= 1'b0;
            unique case (csr_index)
               aes_pkg::CSR_KEY_SIZE: key_size_ff    <= csr_data[1:0];
               aes_pkg::CSR_KEY_W0:   key_word_ff[0] <= csr_data;
               aes_pkg::CSR_KEY_W1:   key_word_ff[1] <= csr_data;
               aes_pkg::CSR_KEY_W2:   key_word_ff[2] <= csr_data;
               default:               key_word_ff[3] <= csr_data;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready) begin
                  op_ff <= req_op;
                  st_ff <= {req_block_hi, req_block_lo};
                  rnd_ff <= '0;
                  if (keys_ready_ff) begin
                     state_ff <= ST_LOAD;
                  end else begin
                     state_ff  <= ST_EXPAND;
                     wi_ff     <= '0;
                     rcon_ff   <= aes_pkg::RCON_INIT;
                     nk_pos_ff <= '0;
                     for (int i = 0; i < 8; i++) begin
                        win_ff[i] <= key_word_ff[i/2][63 - 32*(i%2) -: 32];
                     end
                  end
               end
            end
            ST_EXPAND: begin
               // key words pass first, then the window slides one word a cycle
               if (wi_ff >= {2'b00, nk}) begin
                  for (int i = 0; i < 7; i++) begin
                     win_ff[i] <= (3'(i) == 3'(nk - 4'd1)) ? new_word : win_ff[i+1];
                  end
                  win_ff[7] <= new_word;
                  if (nk_pos_ff == 3'd0) rcon_ff <= aes_pkg::xtime(rcon_ff);
                  nk_pos_ff <= (nk_pos_ff == 3'(nk - 4'd1)) ? 3'd0 : nk_pos_ff + 3'd1;
               end
               hold_word_ff <= cur_word;
               wi_ff <= wi_ff + 6'd1;
               if (wi_ff == total_words - 6'd1) begin
                  state_ff      <= ST_LOAD;
                  keys_ready_ff <= 1'b1;
               end
            end
            ST_LOAD: begin
               state_ff <= ST_FIRST;
            end
            ST_FIRST: begin
               st_ff    <= st_ff ^ {rk_hi_rd_ff, rk_lo_rd_ff};
               rnd_ff   <= 4'd1;
               state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               st_ff  <= round_out;
               rnd_ff <= rnd_ff + 4'd1;
               if (last) begin
                  rsp_valid     <= 1'b1;
                  rsp_result_hi <= round_out[127:64];
                  rsp_result_lo <= round_out[63:0];
                  state_ff      <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_ready) begin
                  rsp_valid <= 1'b0;
                  state_ff  <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

FILE: src/aes_round.sv
// ----------------------------------------------------------------------------
// AES round datapath
// One forward or inverse round on a 128-bit state, with round key added.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_round (
   input  wire logic [127:0] state_i,
   input  wire logic [127:0] key_i,
   input  wire logic         inverse_i,
   input  wire logic         last_i,
   output logic      [127:0] state_o
);

   logic [7:0] s   [16];
   logic [7:0] t   [16];
   logic [7:0] m   [16];
   logic [127:0] pre;

   function automatic logic [7:0] mul_inv(input logic [7:0] a, input logic [3:0] c);
      logic [7:0] a2, a4, a8, p;
      a2 = aes_pkg::xtime(a);
      a4 = aes_pkg::xtime(a2);
      a8 = aes_pkg::xtime(a4);
      p = (c[0] ? a : 8'h00) ^ (c[1] ? a2 : 8'h00) ^ (c[2] ? a4 : 8'h00)
          ^ (c[3] ? a8 : 8'h00);
      return p;
   endfunction

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         s[i] = state_i[127-8*i -: 8];
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (inverse_i) begin
               t[((c + r) % 4) * 4 + r] = aes_pkg::INV_SBOX[s[c*4 + r]];
            end else begin
               t[c*4 + r] = aes_pkg::SBOX[s[((c + r) % 4) * 4 + r]];
            end
         end
      end
      // inverse order: add key before mix
      for (int i = 0; i < 16; i++) begin
         pre[127-8*i -: 8] = inverse_i ? (t[i] ^ key_i[127-8*i -: 8]) : t[i];
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (inverse_i) begin
               m[4*c + r] = mul_inv(pre[127-8*(4*c + r) -: 8], 4'd14)
                  ^ mul_inv(pre[127-8*(4*c + (r+1)%4) -: 8], 4'd11)
                  ^ mul_inv(pre[127-8*(4*c + (r+2)%4) -: 8], 4'd13)
                  ^ mul_inv(pre[127-8*(4*c + (r+3)%4) -: 8], 4'd9);
            end else begin
               m[4*c + r] = aes_pkg::xtime(t[4*c + r])
                  ^ aes_pkg::xtime(t[4*c + (r+1)%4]) ^ t[4*c + (r+1)%4]
                  ^ t[4*c + (r+2)%4] ^ t[4*c + (r+3)%4];
            end
         end
      end
      for (int i = 0; i < 16; i++) begin
         if (last_i) begin
            state_o[127-8*i -: 8] = pre[127-8*i -: 8] ^ (inverse_i ? 8'h00 : key_i[127-8*i -: 8]);
         end else begin
            state_o[127-8*i -: 8] = m[i] ^ (inverse_i ? 8'h00 : key_i[127-8*i -: 8]);
         end
      end
   end

endmodule
`default_nettype wire

FILE: src/aes_checker.sv
// ----------------------------------------------------------------------------
// AES port checker
// Port-level properties of the AES core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] rsp_result_hi
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_hi))
      else $error("result item dropped or changed");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input accepted while result pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("core idle right after accept");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid out of reset");

endmodule

bind aes_block_cipher_128_192_256_core aes_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_result_hi (rsp_result_hi)
);
`default_nettype wire
